// ===== rtl/synth_voice_allocator_core_defines.svh =====
// Assertion macros shared by the voice allocator RTL.
`ifndef SYNTH_VOICE_ALLOCATOR_CORE_DEFINES_SVH
`define SYNTH_VOICE_ALLOCATOR_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SVAC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SVAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

// ===== rtl/svac_pkg.sv =====
// Types, codes and sizes shared by the voice allocator modules.
package svac_pkg;

    localparam int VOICE_COUNT   = 64;
    localparam int CHANNEL_COUNT = 16;
    localparam int VOICE_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int TIME_W        = 32;

    // Item operation codes.
    localparam logic [1:0] OP_MIDI   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_EXPIRE = 2'd3;

    // MIDI message kinds, the high nibble of the status byte.
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    // Controller numbers that the block tracks.
    localparam logic [6:0] CC_MOD_WHEEL = 7'd1;
    localparam logic [6:0] CC_VOLUME    = 7'd7;
    localparam logic [6:0] CC_PAN       = 7'd10;

    // Channel defaults after a full reset.
    localparam logic [6:0]  DEF_MOD_WHEEL = 7'd0;
    localparam logic [6:0]  DEF_VOLUME    = 7'd127;
    localparam logic [6:0]  DEF_PAN       = 7'd64;
    localparam logic [13:0] DEF_BEND      = 14'd8192;

    // Result action codes.
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_STARTED  = 3'd1;
    localparam logic [2:0] ACT_RELEASED = 3'd2;
    localparam logic [2:0] ACT_CHANNEL  = 3'd3;
    localparam logic [2:0] ACT_CLEARED  = 3'd4;
    localparam logic [2:0] ACT_EXPIRED  = 3'd5;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        status_byte;
        logic [6:0]        data_one;
        logic [6:0]        data_two;
        logic [TIME_W-1:0] event_time;
    } svac_req_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [VOICE_W-1:0] voice_index;
        logic               voice_stolen;
        logic [3:0]         channel_out;
        logic [6:0]         note_out;
        logic [6:0]         velocity_out;
        logic [13:0]        value_out;
        logic [6:0]         expired_count;
    } svac_res_t;

    // One entry of the voice memory.
    typedef struct packed {
        logic [6:0]        note;
        logic [3:0]        channel;
        logic [TIME_W-1:0] on_time;
    } svac_voice_t;

    // Flags from the shared scan comparator.
    typedef struct packed {
        logic older;   // scanned start time is below the best one so far
        logic lapsed;  // voice one stage back has outlived its release
    } svac_cmp_t;

endpackage

// ===== rtl/svac_scan_alu.sv =====
// Shared compare and release-time arithmetic used on every scanned voice.
module svac_scan_alu (
    input  logic                        clk,
    input  logic [svac_pkg::TIME_W-1:0] on_time,
    input  logic [svac_pkg::TIME_W-1:0] off_time,
    input  logic [svac_pkg::TIME_W-1:0] best_time,
    input  logic [svac_pkg::TIME_W-1:0] event_time,
    input  logic [svac_pkg::TIME_W-1:0] release_ticks,
    output svac_pkg::svac_cmp_t         cmp
);

    // The release test t - on > max(off - on, 0) + ticks equals
    // t >= on and t > max(off, on) + ticks, so it splits into two stages.
    logic [svac_pkg::TIME_W-1:0] span_end_reg;
    logic                        reached_reg;
    logic [svac_pkg::TIME_W:0]   limit;

    always_ff @(posedge clk)
    begin
        span_end_reg <= (off_time >= on_time) ? off_time : on_time;
        reached_reg  <= (event_time >= on_time);
    end

    assign limit = {1'b0, span_end_reg} + {1'b0, release_ticks};

    assign cmp.older  = (on_time < best_time);
    assign cmp.lapsed = reached_reg && ({1'b0, event_time} > limit);

endmodule

// ===== rtl/synth_voice_allocator_core.sv =====
// Top level of the polyphonic voice allocator with voice stealing.
//
// The block takes one request at a time: a MIDI channel message, an
// all-notes-off, a full reset or an expire request, each with a sample
// timestamp. A request is taken at a rising edge where start is high and
// busy is low, and exactly one result follows, shown for a single cycle
// with done high. The receiver cannot stall the block, so it must capture
// the result in that cycle. Note-on, note-off and expire requests walk the
// whole voice table through one shared compare unit, reading one voice
// memory entry per cycle, and go through a decode state, the scan, a drain
// that flushes the read and compare pipeline and a commit state. Controller
// and pitch bend messages go through decode and a channel output state, and
// all-notes-off, full reset and ignored messages end in decode. The release
// length register may be written through the cfg channel whenever the block
// is idle; a full reset request leaves it alone. Active and released flags
// are flip-flops cleared at once by reset, so the voice memory needs no
// clearing pass.
`include "synth_voice_allocator_core_defines.svh"

module synth_voice_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  svac_pkg::svac_req_t         request,
    output logic                        done,
    output svac_pkg::svac_res_t         result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [svac_pkg::TIME_W-1:0] cfg_data
);

    localparam int VW = svac_pkg::VOICE_W;
    localparam int TW = svac_pkg::TIME_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECODE   = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_DRAIN    = 3'd3;
    localparam logic [2:0] ST_COMMIT   = 3'd4;
    localparam logic [2:0] ST_CHAN_OUT = 3'd5;

    // What a scan is looking for.
    localparam logic [1:0] MODE_ON     = 2'd0;
    localparam logic [1:0] MODE_OFF    = 2'd1;
    localparam logic [1:0] MODE_EXPIRE = 2'd2;

    localparam logic [VW-1:0] LAST_VOICE = VW'(svac_pkg::VOICE_COUNT - 1);

    logic [2:0]          state_reg, state_next;
    logic [1:0]          mode_reg, mode_next;
    svac_pkg::svac_req_t item_reg;
    logic [TW-1:0]       release_ticks_reg;

    // Scan address and pipeline tracking.
    logic [VW-1:0]       idx_reg, idx_next;
    logic                p1_vld_reg;
    logic [VW-1:0]       p1_idx_reg;
    logic                p2_vld_reg;
    logic                p2_elig_reg;
    logic [VW-1:0]       p2_idx_reg;

    // Running scan results.
    logic                hit_free_reg, hit_free_next;
    logic [VW-1:0]       free_idx_reg, free_idx_next;
    logic                hit_rel_reg, hit_rel_next;
    logic [VW-1:0]       rel_idx_reg, rel_idx_next;
    logic                hit_best_reg, hit_best_next;
    logic [VW-1:0]       best_idx_reg, best_idx_next;
    logic [TW-1:0]       best_time_reg, best_time_next;
    logic [6:0]          exp_cnt_reg, exp_cnt_next;

    // Voice table: flags in flip-flops, the rest in memories.
    logic [svac_pkg::VOICE_COUNT-1:0] voice_act_reg;
    logic [svac_pkg::VOICE_COUNT-1:0] voice_rel_reg;
    svac_pkg::svac_voice_t            voice_info_mem [svac_pkg::VOICE_COUNT];
    logic [TW-1:0]                    voice_off_mem  [svac_pkg::VOICE_COUNT];
    svac_pkg::svac_voice_t            rd_info_reg;
    logic [TW-1:0]                    rd_off_reg;

    // Per-channel controller state.
    logic [6:0]  chan_mod_reg  [svac_pkg::CHANNEL_COUNT];
    logic [6:0]  chan_vol_reg  [svac_pkg::CHANNEL_COUNT];
    logic [6:0]  chan_pan_reg  [svac_pkg::CHANNEL_COUNT];
    logic [13:0] chan_bend_reg [svac_pkg::CHANNEL_COUNT];

    logic                done_reg, done_next;
    svac_pkg::svac_res_t res_reg, res_next;

    svac_pkg::svac_cmp_t cmp;

    // Decoded fields of the held request.
    logic [3:0]    kind;
    logic [3:0]    chan;
    logic          chan_ok;
    logic          ctrl_known;

    // Scan stage one signals.
    logic          cur_act;
    logic          cur_rel;
    logic          cand;

    // Commit selection and control actions.
    logic [VW-1:0] pick_idx;
    logic          do_clear;
    logic          do_chan_reset;
    logic          do_chan_write;
    logic          do_start;
    logic          do_release;
    logic          do_expire;

    assign kind       = item_reg.status_byte[7:4];
    assign chan       = item_reg.status_byte[3:0];
    assign chan_ok    = (32'(chan) < 32'(svac_pkg::CHANNEL_COUNT));
    assign ctrl_known = (item_reg.data_one == svac_pkg::CC_MOD_WHEEL) ||
                        (item_reg.data_one == svac_pkg::CC_VOLUME) ||
                        (item_reg.data_one == svac_pkg::CC_PAN);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;

    svac_scan_alu u_alu (
        .clk           (clk),
        .on_time       (rd_info_reg.on_time),
        .off_time      (rd_off_reg),
        .best_time     (best_time_reg),
        .event_time    (item_reg.event_time),
        .release_ticks (release_ticks_reg),
        .cmp           (cmp)
    );

    // Stage one looks at the entry whose memory read just returned.
    assign cur_act = voice_act_reg[p1_idx_reg];
    assign cur_rel = voice_rel_reg[p1_idx_reg];
    assign cand    = (mode_reg == MODE_ON) ||
                     ((mode_reg == MODE_OFF) && cur_act && !cur_rel &&
                      (rd_info_reg.note == item_reg.data_one) &&
                      (rd_info_reg.channel == chan));

    // A note-on prefers a free voice, then a released one, then the oldest.
    always_comb
    begin
        if (hit_free_reg)
        begin
            pick_idx = free_idx_reg;
        end
        else if (hit_rel_reg)
        begin
            pick_idx = rel_idx_reg;
        end
        else
        begin
            pick_idx = best_idx_reg;
        end
    end

    // Expired voices are cleared at stage two, behind the scan front.
    assign do_expire = p2_vld_reg && p2_elig_reg && cmp.lapsed;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        hit_free_next  = hit_free_reg;
        free_idx_next  = free_idx_reg;
        hit_rel_next   = hit_rel_reg;
        rel_idx_next   = rel_idx_reg;
        hit_best_next  = hit_best_reg;
        best_idx_next  = best_idx_reg;
        best_time_next = best_time_reg;
        exp_cnt_next   = exp_cnt_reg;
        done_next      = 1'b0;
        res_next       = '0;
        do_clear       = 1'b0;
        do_chan_reset  = 1'b0;
        do_chan_write  = 1'b0;
        do_start       = 1'b0;
        do_release     = 1'b0;

        // Scan bookkeeping runs whenever stage one holds an entry.
        if (p1_vld_reg)
        begin
            if ((mode_reg == MODE_ON) && !hit_free_reg && !cur_act)
            begin
                hit_free_next = 1'b1;
                free_idx_next = p1_idx_reg;
            end
            if ((mode_reg == MODE_ON) && !hit_rel_reg && cur_rel)
            begin
                hit_rel_next = 1'b1;
                rel_idx_next = p1_idx_reg;
            end
            if (cand && (!hit_best_reg || cmp.older))
            begin
                hit_best_next  = 1'b1;
                best_idx_next  = p1_idx_reg;
                best_time_next = rd_info_reg.on_time;
            end
        end
        if (do_expire && (exp_cnt_reg != 7'h7F))
        begin
            exp_cnt_next = exp_cnt_reg + 7'd1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                idx_next      = '0;
                hit_free_next = 1'b0;
                hit_rel_next  = 1'b0;
                hit_best_next = 1'b0;
                exp_cnt_next  = '0;
                state_next    = ST_IDLE;
                done_next     = 1'b1;
                case (item_reg.op)
                    svac_pkg::OP_CLEAR,
                    svac_pkg::OP_RESET:
                    begin
                        do_clear        = 1'b1;
                        do_chan_reset   = (item_reg.op == svac_pkg::OP_RESET);
                        res_next.action = svac_pkg::ACT_CLEARED;
                    end
                    svac_pkg::OP_EXPIRE:
                    begin
                        mode_next  = MODE_EXPIRE;
                        state_next = ST_SCAN;
                        done_next  = 1'b0;
                    end
                    default:
                    begin
                        if (!chan_ok)
                        begin
                            res_next.action = svac_pkg::ACT_NONE;
                        end
                        else if ((kind == svac_pkg::KIND_NOTE_ON) &&
                                 (item_reg.data_two != 7'd0))
                        begin
                            mode_next  = MODE_ON;
                            state_next = ST_SCAN;
                            done_next  = 1'b0;
                        end
                        else if ((kind == svac_pkg::KIND_NOTE_ON) ||
                                 (kind == svac_pkg::KIND_NOTE_OFF))
                        begin
                            mode_next  = MODE_OFF;
                            state_next = ST_SCAN;
                            done_next  = 1'b0;
                        end
                        else if ((kind == svac_pkg::KIND_BEND) ||
                                 ((kind == svac_pkg::KIND_CTRL) && ctrl_known))
                        begin
                            do_chan_write = 1'b1;
                            state_next    = ST_CHAN_OUT;
                            done_next     = 1'b0;
                        end
                        else
                        begin
                            res_next.action = svac_pkg::ACT_NONE;
                        end
                    end
                endcase
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_VOICE)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_vld_reg && !p2_vld_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (mode_reg)
                    MODE_ON:
                    begin
                        do_start              = 1'b1;
                        res_next.action       = svac_pkg::ACT_STARTED;
                        res_next.voice_index  = pick_idx;
                        res_next.voice_stolen = voice_act_reg[pick_idx];
                        res_next.channel_out  = chan;
                        res_next.note_out     = item_reg.data_one;
                        res_next.velocity_out = item_reg.data_two;
                    end
                    MODE_OFF:
                    begin
                        if (hit_best_reg)
                        begin
                            do_release           = 1'b1;
                            res_next.action      = svac_pkg::ACT_RELEASED;
                            res_next.voice_index = best_idx_reg;
                            res_next.channel_out = chan;
                            res_next.note_out    = item_reg.data_one;
                        end
                    end
                    default:
                    begin
                        res_next.action        = svac_pkg::ACT_EXPIRED;
                        res_next.expired_count = exp_cnt_reg;
                    end
                endcase
            end
            ST_CHAN_OUT:
            begin
                // The reported value is read back from the channel record.
                state_next           = ST_IDLE;
                done_next            = 1'b1;
                res_next.action      = svac_pkg::ACT_CHANNEL;
                res_next.channel_out = chan;
                if (kind == svac_pkg::KIND_BEND)
                begin
                    res_next.value_out = chan_bend_reg[chan];
                end
                else if (item_reg.data_one == svac_pkg::CC_MOD_WHEEL)
                begin
                    res_next.value_out = {7'd0, chan_mod_reg[chan]};
                end
                else if (item_reg.data_one == svac_pkg::CC_VOLUME)
                begin
                    res_next.value_out = {7'd0, chan_vol_reg[chan]};
                end
                else
                begin
                    res_next.value_out = {7'd0, chan_pan_reg[chan]};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mode_reg          <= MODE_ON;
            release_ticks_reg <= '0;
            p1_vld_reg        <= 1'b0;
            p2_vld_reg        <= 1'b0;
            done_reg          <= 1'b0;
            hit_free_reg      <= 1'b0;
            hit_rel_reg       <= 1'b0;
            hit_best_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            p1_vld_reg   <= (state_reg == ST_SCAN);
            p2_vld_reg   <= p1_vld_reg;
            done_reg     <= done_next;
            hit_free_reg <= hit_free_next;
            hit_rel_reg  <= hit_rel_next;
            hit_best_reg <= hit_best_next;
            if (cfg_valid && cfg_ready)
            begin
                release_ticks_reg <= cfg_data;
            end
        end
    end

    // Payload and scan data.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= request;
        end
        idx_reg       <= idx_next;
        p1_idx_reg    <= idx_reg;
        p2_idx_reg    <= p1_idx_reg;
        p2_elig_reg   <= p1_vld_reg && (mode_reg == MODE_EXPIRE) && cur_act && cur_rel;
        free_idx_reg  <= free_idx_next;
        rel_idx_reg   <= rel_idx_next;
        best_idx_reg  <= best_idx_next;
        best_time_reg <= best_time_next;
        exp_cnt_reg   <= exp_cnt_next;
        res_reg       <= res_next;
    end

    // Voice memories: one read per cycle at the scan address, written at commit.
    always_ff @(posedge clk)
    begin
        rd_info_reg <= voice_info_mem[idx_reg];
        rd_off_reg  <= voice_off_mem[idx_reg];
        if (do_start)
        begin
            voice_info_mem[pick_idx] <= '{note:    item_reg.data_one,
                                          channel: chan,
                                          on_time: item_reg.event_time};
        end
        if (do_release)
        begin
            voice_off_mem[best_idx_reg] <= item_reg.event_time;
        end
    end

    // Active and released flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_act_reg <= '0;
            voice_rel_reg <= '0;
        end
        else if (do_clear)
        begin
            voice_act_reg <= '0;
            voice_rel_reg <= '0;
        end
        else
        begin
            if (do_expire)
            begin
                voice_act_reg[p2_idx_reg] <= 1'b0;
                voice_rel_reg[p2_idx_reg] <= 1'b0;
            end
            if (do_start)
            begin
                voice_act_reg[pick_idx] <= 1'b1;
                voice_rel_reg[pick_idx] <= 1'b0;
            end
            if (do_release)
            begin
                voice_rel_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    // Channel records.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < svac_pkg::CHANNEL_COUNT; c++)
            begin
                chan_mod_reg[c]  <= svac_pkg::DEF_MOD_WHEEL;
                chan_vol_reg[c]  <= svac_pkg::DEF_VOLUME;
                chan_pan_reg[c]  <= svac_pkg::DEF_PAN;
                chan_bend_reg[c] <= svac_pkg::DEF_BEND;
            end
        end
        else if (do_chan_reset)
        begin
            for (int c = 0; c < svac_pkg::CHANNEL_COUNT; c++)
            begin
                chan_mod_reg[c]  <= svac_pkg::DEF_MOD_WHEEL;
                chan_vol_reg[c]  <= svac_pkg::DEF_VOLUME;
                chan_pan_reg[c]  <= svac_pkg::DEF_PAN;
                chan_bend_reg[c] <= svac_pkg::DEF_BEND;
            end
        end
        else if (do_chan_write)
        begin
            if (kind == svac_pkg::KIND_BEND)
            begin
                chan_bend_reg[chan] <= {item_reg.data_two, item_reg.data_one};
            end
            else if (item_reg.data_one == svac_pkg::CC_MOD_WHEEL)
            begin
                chan_mod_reg[chan] <= item_reg.data_two;
            end
            else if (item_reg.data_one == svac_pkg::CC_VOLUME)
            begin
                chan_vol_reg[chan] <= item_reg.data_two;
            end
            else
            begin
                chan_pan_reg[chan] <= item_reg.data_two;
            end
        end
    end

    // A result is only ever shown as the sequencer returns to idle.
    `SVAC_ASSERT_NOW(a_done_when_idle, done, state_reg == ST_IDLE)
    // An accepted request keeps the block busy in the next cycle.
    `SVAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    // A voice can only be released while it is active.
    `SVAC_ASSERT_NOW(a_rel_implies_act, 1'b1, (voice_rel_reg & ~voice_act_reg) == '0)
    // An expire request never frees more voices than the table holds.
    `SVAC_ASSERT_NOW(a_expire_count, done && (res_reg.action == svac_pkg::ACT_EXPIRED),
        res_reg.expired_count <= 7'(svac_pkg::VOICE_COUNT))

endmodule

// ===== sim/tb_synth_voice_allocator_core.sv =====
// Self-checking testbench for the polyphonic voice allocator core.
`timescale 1ns / 1ps

module tb_synth_voice_allocator_core;
    import svac_pkg::*;

    // A stretch this long with no request, result or register write means the
    // block has hung. The longest correct quiet stretch stays below the longest
    // sender gap plus one whole table scan.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF    = 80;
    localparam int REPORT_MAX  = 10;

    // Message kinds that the block does not handle; they must answer with no action.
    localparam logic [3:0] KIND_DATA       = 4'h0;
    localparam logic [3:0] KIND_POLY_TOUCH = 4'hA;
    localparam logic [3:0] KIND_PROGRAM    = 4'hC;
    localparam logic [3:0] KIND_CHAN_TOUCH = 4'hD;
    localparam logic [3:0] KIND_SYSTEM     = 4'hF;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    svac_req_t         request   = '0;
    logic              done;
    svac_res_t         result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [TIME_W-1:0] cfg_data  = '0;

    synth_voice_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Our own copy of the release length register and of the voice and
    // channel tables, updated at the edge where each request is accepted.
    logic [TIME_W-1:0] release_len;
    bit                tbl_active   [VOICE_COUNT];
    bit                tbl_released [VOICE_COUNT];
    logic [6:0]        tbl_note     [VOICE_COUNT];
    logic [3:0]        tbl_chan     [VOICE_COUNT];
    logic [6:0]        tbl_velocity [VOICE_COUNT];
    logic [TIME_W-1:0] tbl_start    [VOICE_COUNT];
    logic [TIME_W-1:0] tbl_stop     [VOICE_COUNT];
    logic [6:0]        ch_mod       [CHANNEL_COUNT];
    logic [6:0]        ch_vol       [CHANNEL_COUNT];
    logic [6:0]        ch_pan       [CHANNEL_COUNT];
    logic [13:0]       ch_bend      [CHANNEL_COUNT];

    // Answers still owed by the block, oldest first.
    svac_res_t pending_answers[$];

    // Running sample clock used to timestamp generated requests.
    logic [TIME_W-1:0] sample_now;
    // When clear, the sender issues requests back to back.
    bit                idle_on;

    int unsigned fault_count    = 0;
    int unsigned requests_sent  = 0;
    int unsigned count_started  = 0;
    int unsigned count_stolen   = 0;
    int unsigned count_released = 0;
    int unsigned count_freed    = 0;
    int unsigned count_updates  = 0;
    int unsigned count_clears   = 0;
    int unsigned stall_cycles   = 0;

    function automatic void clear_voice_table();
        int i;
        for (i = 0; i < VOICE_COUNT; i++)
        begin
            tbl_active[i]   = 1'b0;
            tbl_released[i] = 1'b0;
            tbl_note[i]     = '0;
            tbl_chan[i]     = '0;
            tbl_velocity[i] = '0;
            tbl_start[i]    = '0;
            tbl_stop[i]     = '0;
        end
    endfunction

    function automatic void restore_channels();
        int c;
        for (c = 0; c < CHANNEL_COUNT; c++)
        begin
            ch_mod[c]  = DEF_MOD_WHEEL;
            ch_vol[c]  = DEF_VOLUME;
            ch_pan[c]  = DEF_PAN;
            ch_bend[c] = DEF_BEND;
        end
    endfunction

    // Applies one accepted request to the table copy and returns the answer
    // the block must give for it.
    function automatic svac_res_t predict_allocation(input svac_req_t r);
        svac_res_t         ans;
        logic [3:0]        kind;
        logic [3:0]        ch;
        int                pick;
        int                i;
        logic [TIME_W:0]   age;
        logic [TIME_W:0]   held_for;
        ans  = '0;
        kind = r.status_byte[7:4];
        ch   = r.status_byte[3:0];
        if (r.op == OP_CLEAR || r.op == OP_RESET)
        begin
            clear_voice_table();
            if (r.op == OP_RESET)
                restore_channels();
            ans.action = ACT_CLEARED;
        end
        else if (r.op == OP_EXPIRE)
        begin
            ans.action = ACT_EXPIRED;
            for (i = 0; i < VOICE_COUNT; i++)
            begin
                // A voice stamped after the expire time never frees; a note-off
                // stamped before the note-on counts as no hold time at all.
                if (tbl_active[i] && tbl_released[i] && r.event_time >= tbl_start[i])
                begin
                    held_for = (tbl_stop[i] >= tbl_start[i]) ?
                               {1'b0, tbl_stop[i]} - {1'b0, tbl_start[i]} : '0;
                    age      = {1'b0, r.event_time} - {1'b0, tbl_start[i]};
                    if (age > held_for + {1'b0, release_len})
                    begin
                        tbl_active[i]   = 1'b0;
                        tbl_released[i] = 1'b0;
                        if (ans.expired_count != 7'd127)
                            ans.expired_count = ans.expired_count + 7'd1;
                    end
                end
            end
        end
        else if (32'(ch) >= CHANNEL_COUNT)
        begin
            ans = '0;
        end
        else if (kind == KIND_NOTE_ON && r.data_two != 7'd0)
        begin
            // Free voice first, then a released one, then the oldest start.
            pick = -1;
            for (i = 0; i < VOICE_COUNT && pick < 0; i++)
                if (!tbl_active[i])
                    pick = i;
            for (i = 0; i < VOICE_COUNT && pick < 0; i++)
                if (tbl_released[i])
                    pick = i;
            if (pick < 0)
            begin
                pick = 0;
                for (i = 1; i < VOICE_COUNT; i++)
                    if (tbl_start[i] < tbl_start[pick])
                        pick = i;
            end
            ans.action       = ACT_STARTED;
            ans.voice_index  = VOICE_W'(pick);
            ans.voice_stolen = tbl_active[pick];
            ans.channel_out  = ch;
            ans.note_out     = r.data_one;
            ans.velocity_out = r.data_two;
            tbl_active[pick]   = 1'b1;
            tbl_released[pick] = 1'b0;
            tbl_note[pick]     = r.data_one;
            tbl_chan[pick]     = ch;
            tbl_velocity[pick] = r.data_two;
            tbl_start[pick]    = r.event_time;
            tbl_stop[pick]     = '0;
        end
        else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF)
        begin
            // The held voice of this channel and note that started first.
            pick = -1;
            for (i = 0; i < VOICE_COUNT; i++)
                if (tbl_active[i] && !tbl_released[i] && tbl_note[i] == r.data_one &&
                    tbl_chan[i] == ch)
                    if (pick < 0 || tbl_start[i] < tbl_start[pick])
                        pick = i;
            if (pick >= 0)
            begin
                tbl_released[pick] = 1'b1;
                tbl_stop[pick]     = r.event_time;
                ans.action         = ACT_RELEASED;
                ans.voice_index    = VOICE_W'(pick);
                ans.channel_out    = ch;
                ans.note_out       = r.data_one;
            end
        end
        else if (kind == KIND_BEND)
        begin
            ch_bend[ch]     = {r.data_two, r.data_one};
            ans.action      = ACT_CHANNEL;
            ans.channel_out = ch;
            ans.value_out   = ch_bend[ch];
        end
        else if (kind == KIND_CTRL && (r.data_one == CC_MOD_WHEEL ||
                 r.data_one == CC_VOLUME || r.data_one == CC_PAN))
        begin
            if (r.data_one == CC_MOD_WHEEL)
                ch_mod[ch] = r.data_two;
            else if (r.data_one == CC_VOLUME)
                ch_vol[ch] = r.data_two;
            else
                ch_pan[ch] = r.data_two;
            ans.action      = ACT_CHANNEL;
            ans.channel_out = ch;
            ans.value_out   = 14'(r.data_two);
        end
        return ans;
    endfunction

    // Sender gaps: half none, most of the rest short, a few longer than a
    // whole table scan so that requests land on every cycle of the work.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 50)
            return 0;
        if (roll < 80)
            return $urandom_range(1, 8);
        if (roll < 95)
            return $urandom_range(9, 90);
        return $urandom_range(91, 300);
    endfunction

    // Sends one request, records its answer at the accepting edge, then idles.
    // Start is left high after a zero gap so the next request follows at once.
    task automatic issue_request(input svac_req_t r);
        svac_res_t   answer;
        int unsigned gap;
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        answer = predict_allocation(r);
        pending_answers.push_back(answer);
        requests_sent++;
        case (answer.action)
            ACT_STARTED:
            begin
                count_started++;
                if (answer.voice_stolen)
                    count_stolen++;
            end
            ACT_RELEASED: count_released++;
            ACT_CHANNEL:  count_updates++;
            ACT_CLEARED:  count_clears++;
            ACT_EXPIRED:  count_freed += 32'(answer.expired_count);
            default: ;
        endcase
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Only called with nothing in flight.
    task automatic write_release_ticks(input logic [TIME_W-1:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        release_len = ticks;
        cfg_valid <= 1'b0;
    endtask

    function automatic svac_req_t make_req(input logic [1:0] op, input logic [7:0] status,
                                           input logic [6:0] d1, input logic [6:0] d2,
                                           input logic [TIME_W-1:0] stamp);
        svac_req_t r;
        r.op          = op;
        r.status_byte = status;
        r.data_one    = d1;
        r.data_two    = d2;
        r.event_time  = stamp;
        return r;
    endfunction

    // Mostly a few channels and a narrow band of notes, so that the same note
    // is often held twice; now and then anything.
    function automatic logic [3:0] pick_channel();
        if ($urandom_range(0, 3) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, 2));
    endfunction

    function automatic logic [6:0] pick_note();
        if ($urandom_range(0, 3) == 0)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(60, 67));
    endfunction

    function automatic svac_req_t make_note_on();
        return make_req(OP_MIDI, {KIND_NOTE_ON, pick_channel()}, pick_note(),
                        7'($urandom_range(1, 127)), sample_now);
    endfunction

    // Releases a note that is really held where there is one, as either a
    // note-off or a note-on with zero velocity.
    function automatic svac_req_t make_note_off();
        int         held[$];
        int         v;
        logic [3:0] kind;
        for (v = 0; v < VOICE_COUNT; v++)
            if (tbl_active[v] && !tbl_released[v])
                held.push_back(v);
        kind = $urandom_range(0, 1) ? KIND_NOTE_OFF : KIND_NOTE_ON;
        if (held.size() == 0)
            return make_req(OP_MIDI, {KIND_NOTE_OFF, pick_channel()}, pick_note(),
                            7'($urandom), sample_now);
        v = held[$urandom_range(0, held.size() - 1)];
        return make_req(OP_MIDI, {kind, tbl_chan[v]}, tbl_note[v],
                        (kind == KIND_NOTE_ON) ? 7'd0 : 7'($urandom), sample_now);
    endfunction

    // One request of a plausible performance: notes on and off, controllers,
    // bends, expire requests, clears and resets, with a little noise.
    function automatic svac_req_t compose_phrase_item(input int unsigned step_max,
                                                      input int unsigned on_pct);
        int unsigned roll;
        logic [6:0]  ctl;
        sample_now = sample_now + $urandom_range(0, step_max);
        if ($urandom_range(0, 99) < on_pct)
            return make_note_on();
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return make_note_off();
        if (roll < 62)
        begin
            case ($urandom_range(0, 3))
                0:       ctl = CC_MOD_WHEEL;
                1:       ctl = CC_VOLUME;
                2:       ctl = CC_PAN;
                default: ctl = 7'($urandom);
            endcase
            return make_req(OP_MIDI, {KIND_CTRL, pick_channel()}, ctl, 7'($urandom), sample_now);
        end
        if (roll < 70)
            return make_req(OP_MIDI, {KIND_BEND, pick_channel()}, 7'($urandom), 7'($urandom),
                            sample_now);
        if (roll < 87)
            return make_req(OP_EXPIRE, 8'($urandom), 7'($urandom), 7'($urandom), sample_now);
        if (roll < 90)
            // An expire stamped earlier than some of the voices.
            return make_req(OP_EXPIRE, 8'($urandom), 7'($urandom), 7'($urandom),
                            sample_now - $urandom_range(0, 4 * step_max));
        if (roll < 96)
            return make_req(OP_MIDI, 8'($urandom), 7'($urandom), 7'($urandom), sample_now);
        if (roll < 98)
            return make_req(OP_CLEAR, 8'($urandom), 7'($urandom), 7'($urandom), sample_now);
        return make_req(OP_RESET, 8'($urandom), 7'($urandom), 7'($urandom), sample_now);
    endfunction

    // Field extremes, every message kind and the corner cases of note-off and
    // expire, with the release length still at its reset value of zero.
    task automatic test_directed_cases();
        issue_request(make_req(OP_MIDI, {KIND_NOTE_ON, 4'd0}, 7'd0, 7'd1, 32'd0));
        issue_request(make_req(OP_MIDI, {KIND_NOTE_ON, 4'd15}, 7'd127, 7'd127, 32'hFFFF_FFFF));
        issue_request(make_req(OP_MIDI, {KIND_NOTE_ON, 4'd5}, 7'd60, 7'd64, 32'd100));
        // The same note again: the note-off must take the earlier voice.
        issue_request(make_req(OP_MIDI, {KIND_NOTE_ON, 4'd5}, 7'd60, 7'd90, 32'd200));
        issue_request(make_req(OP_MIDI, {KIND_NOTE_OFF, 4'd5}, 7'd60, 7'd127, 32'd150));
        // Zero velocity is a note-off, here stamped before its voice started.
        issue_request(make_req(OP_MIDI, {KIND_NOTE_ON, 4'd5}, 7'd60, 7'd0, 32'd160));
        // Nothing left to release for these.
        issue_request(make_req(OP_MIDI, {KIND_NOTE_OFF, 4'd5}, 7'd60, 7'd0, 32'd170));
        issue_request(make_req(OP_MIDI, {KIND_NOTE_OFF, 4'd9}, 7'd33, 7'd10, 32'd170));
        issue_request(make_req(OP_MIDI, {KIND_BEND, 4'd3}, 7'd127, 7'd127, 32'd180));
        issue_request(make_req(OP_MIDI, {KIND_BEND, 4'd3}, 7'd0, 7'd0, 32'd180));
        issue_request(make_req(OP_MIDI, {KIND_BEND, 4'd0}, 7'd0, 7'd64, 32'd180));
        issue_request(make_req(OP_MIDI, {KIND_CTRL, 4'd2}, CC_MOD_WHEEL, 7'd127, 32'd190));
        issue_request(make_req(OP_MIDI, {KIND_CTRL, 4'd2}, CC_VOLUME, 7'd0, 32'd190));
        issue_request(make_req(OP_MIDI, {KIND_CTRL, 4'd15}, CC_PAN, 7'd64, 32'd190));
        // Untracked controllers and message kinds change nothing.
        issue_request(make_req(OP_MIDI, {KIND_CTRL, 4'd2}, 7'd0, 7'd55, 32'd190));
        issue_request(make_req(OP_MIDI, {KIND_CTRL, 4'd2}, 7'd127, 7'd55, 32'd190));
        issue_request(make_req(OP_MIDI, {KIND_POLY_TOUCH, 4'd1}, 7'd60, 7'd10, 32'd190));
        issue_request(make_req(OP_MIDI, {KIND_PROGRAM, 4'd7}, 7'd5, 7'd0, 32'd190));
        issue_request(make_req(OP_MIDI, {KIND_CHAN_TOUCH, 4'd0}, 7'd100, 7'd0, 32'd190));
        issue_request(make_req(OP_MIDI, {KIND_SYSTEM, 4'd15}, 7'd127, 7'd127, 32'd190));
        issue_request(make_req(OP_MIDI, {KIND_DATA, 4'd0}, 7'd60, 7'd100, 32'd190));
        // Too early for the first released voice, before the start of the second.
        issue_request(make_req(OP_EXPIRE, 8'h00, 7'd0, 7'd0, 32'd150));
        // Both released voices have now run out.
        issue_request(make_req(OP_EXPIRE, 8'h00, 7'd0, 7'd0, 32'd250));
        issue_request(make_req(OP_CLEAR, 8'h00, 7'd0, 7'd0, 32'd300));
        issue_request(make_req(OP_RESET, 8'hFF, 7'd127, 7'd127, 32'hFFFF_FFFF));
        sample_now = 32'd1000;
    endtask

    // Fills the whole table, mostly with equal start times, then keeps adding
    // notes so that the oldest voice is taken over, lowest index on a tie.
    task automatic test_voice_stealing();
        issue_request(make_req(OP_CLEAR, 8'h00, 7'd0, 7'd0, sample_now));
        repeat (80)
        begin
            sample_now = sample_now + $urandom_range(0, 1);
            issue_request(make_note_on());
        end
        // Released voices are reused before anything else is stolen.
        repeat (12) issue_request(make_note_off());
        repeat (16) issue_request(make_note_on());
        sample_now = sample_now + 1000;
        issue_request(make_req(OP_EXPIRE, 8'h00, 7'd0, 7'd0, sample_now));
        repeat (20) issue_request(make_note_on());
    endtask

    // Random performances under several release lengths, the extremes among
    // them. One setting runs with no idling, one runs the clock through its wrap.
    task automatic test_release_lengths();
        logic [TIME_W-1:0] lengths[6];
        int unsigned       step_max;
        int unsigned       on_pct;
        int                p;
        lengths[0] = '0;
        lengths[1] = 32'd1;
        lengths[2] = 32'd37;
        lengths[3] = 32'd1000;
        lengths[4] = 32'hFFFF_FFFF;
        lengths[5] = $urandom_range(2, 5000);
        for (p = 0; p < 6; p++)
        begin
            drain_results();
            write_release_ticks(lengths[p]);
            idle_on = (p != 2);
            if (p == 3)
                sample_now = 32'hFFFF_F000 + $urandom_range(0, 255);
            step_max = (lengths[p] > 4000) ? 400 : lengths[p] / 4 + 8;
            // With voices never freeing, lean on note-ons to force stealing.
            on_pct = (p == 4) ? 65 : 40;
            repeat (200) issue_request(compose_phrase_item(step_max, on_pct));
        end
        idle_on = 1'b1;
    endtask

    // Fields drawn at random across their whole range.
    task automatic test_random_noise();
        logic [1:0] op;
        repeat (290)
        begin
            op = ($urandom_range(0, 9) < 6) ? OP_MIDI : 2'($urandom_range(1, 3));
            issue_request(make_req(op, 8'($urandom), 7'($urandom), 7'($urandom), $urandom));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Each strobed result is matched against the oldest outstanding answer.
    always @(posedge clk)
    begin : result_check
        svac_res_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (pending_answers.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("%0t: result with no request outstanding: %h", $time, result);
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("action", 32'(want.action), 32'(result.action));
                check_field("voice_index", 32'(want.voice_index), 32'(result.voice_index));
                check_field("voice_stolen", 32'(want.voice_stolen), 32'(result.voice_stolen));
                check_field("channel_out", 32'(want.channel_out), 32'(result.channel_out));
                check_field("note_out", 32'(want.note_out), 32'(result.note_out));
                check_field("velocity_out", 32'(want.velocity_out),
                            32'(result.velocity_out));
                check_field("value_out", 32'(want.value_out), 32'(result.value_out));
                check_field("expired_count", 32'(want.expired_count),
                            32'(result.expired_count));
            end
        end
    end

    // Any handshake counts as progress; a long silence ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        release_len = '0;
        clear_voice_table();
        restore_channels();
        sample_now = '0;
        idle_on    = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_voice_stealing();
        test_release_lengths();
        test_random_noise();

        drain_results();
        repeat (HOLD_OFF) @(posedge clk);

        $display("Ran %0d requests: %0d voices started, %0d of them stolen, %0d released.",
                 requests_sent, count_started, count_stolen, count_released);
        $display("Expire requests freed %0d voices; %0d channel updates, %0d table clears.",
                 count_freed, count_updates, count_clears);
        if (fault_count == 0 && pending_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
